[design/motor_arming_run_sequencer_top_defines.svh]
// Assertion macros used by the checker file of the motor arming and run sequencer.
`ifndef MOTOR_ARMING_RUN_SEQUENCER_TOP_DEFINES_SVH
`define MOTOR_ARMING_RUN_SEQUENCER_TOP_DEFINES_SVH

// Checked on every edge outside reset.
`define MARS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included.
`define MARS_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[design/mars_pkg.sv]
// Shared types, codes and constants of the motor arming and run sequencer.
package mars_pkg;

   localparam int unsigned IdWidth      = 29;
   localparam int unsigned PayloadWidth = 32;
   localparam int unsigned SpeedWidth   = 16;
   localparam int unsigned TargetWidth  = 14;
   localparam int unsigned ArmCntWidth  = 17;
   localparam int unsigned CsrIdxWidth  = 2;

   localparam logic [IdWidth-1:0] ID_ARM   = 29'h700;
   localparam logic [IdWidth-1:0] ID_SPEED = 29'h701;
   localparam logic [IdWidth-1:0] ID_TELEM = 29'h702;
   localparam logic [7:0]         ARM_KEY  = 8'hAA;

   // floor(x / 6) == (x * 43691) >> 18 for every 16-bit x
   localparam logic [SpeedWidth-1:0] DIV6_MUL   = 16'd43691;
   localparam int unsigned           DIV6_SHIFT = 18;

   localparam logic [ArmCntWidth-1:0] ARM_CNT_MAX = {ArmCntWidth{1'b1}};

   // register indexes
   localparam logic [CsrIdxWidth-1:0] CSR_SPEED_MIN    = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_SPEED_MAX    = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_ARMING_TICKS = 2'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_STOP_TICKS   = 2'd3;

   // sequencer modes
   localparam logic [2:0] MODE_ARMING  = 3'd0;
   localparam logic [2:0] MODE_ARMED   = 3'd1;
   localparam logic [2:0] MODE_RUNINIT = 3'd2;
   localparam logic [2:0] MODE_RUN     = 3'd3;
   localparam logic [2:0] MODE_STOP    = 3'd4;

   // request classes
   localparam logic [2:0] OP_TICK  = 3'd0;
   localparam logic [2:0] OP_ARM   = 3'd1;
   localparam logic [2:0] OP_SPEED = 3'd2;
   localparam logic [2:0] OP_TELEM = 3'd3;
   localparam logic [2:0] OP_NONE  = 3'd4;

   typedef struct packed {
      logic [2:0]             op;
      logic                   arm_key;
      logic [SpeedWidth-1:0]  speed;
      logic [TargetWidth-1:0] speed_div;
      logic                   running;
      logic                   accepted;
   } req_item_type;

   typedef struct packed {
      logic                   ramp_valid;
      logic [TargetWidth-1:0] ramp_target;
      logic                   start_request;
      logic                   stop_request;
      logic                   telemetry_request;
      logic [2:0]             mode;
      logic                   arm_enabled;
   } rsp_item_type;

endpackage

[design/mars_front.sv]
// Front end: classifies requests and holds them in a two-entry queue.
module mars_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   input  logic                                req_action,
   input  logic [mars_pkg::IdWidth-1:0]        req_frame_id,
   input  logic [mars_pkg::PayloadWidth-1:0]   req_frame_payload,
   input  logic                                req_motor_running,
   input  logic                                req_start_accepted,
   output logic                                req_full,
   output mars_pkg::req_item_type              q_item,
   output logic                                q_valid,
   input  logic                                q_deq
);

   mars_pkg::req_item_type q_ff [2];
   logic                   wr_ptr_ff, wr_ptr_in;
   logic                   rd_ptr_ff, rd_ptr_in;
   logic [1:0]             count_ff, count_in;
   mars_pkg::req_item_type cls;
   logic [31:0]            prod;
   logic                   enq;

   always_comb begin
      prod          = req_frame_payload[15:0] * mars_pkg::DIV6_MUL;
      cls.arm_key   = (req_frame_payload[7:0] == mars_pkg::ARM_KEY);
      cls.speed     = req_frame_payload[15:0];
      cls.speed_div = prod[mars_pkg::DIV6_SHIFT +: mars_pkg::TargetWidth];
      cls.running   = req_motor_running;
      cls.accepted  = req_start_accepted;
      if (!req_action) begin
         cls.op = mars_pkg::OP_TICK;
      end else if (req_frame_id == mars_pkg::ID_ARM) begin
         cls.op = mars_pkg::OP_ARM;
      end else if (req_frame_id == mars_pkg::ID_SPEED) begin
         cls.op = mars_pkg::OP_SPEED;
      end else if (req_frame_id == mars_pkg::ID_TELEM) begin
         cls.op = mars_pkg::OP_TELEM;
      end else begin
         cls.op = mars_pkg::OP_NONE;
      end
   end

   assign req_full = (count_ff == 2'd2);
   assign enq      = req_push && !req_full;
   assign q_valid  = (count_ff != 2'd0);
   assign q_item   = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = enq ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_deq ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, enq} - {1'b0, q_deq};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

[design/mars_back.sv]
// Back end: sequencer state, configuration registers and the result queue.
module mars_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [mars_pkg::CsrIdxWidth-1:0]    csr_index,
   input  logic [mars_pkg::SpeedWidth-1:0]     csr_data,
   input  mars_pkg::req_item_type              q_item,
   input  logic                                q_valid,
   output logic                                q_deq,
   output mars_pkg::rsp_item_type              rsp_item,
   output logic                                rsp_empty,
   input  logic                                rsp_pop
);

   logic [15:0] speed_min_ff, speed_max_ff, arming_ticks_ff, stop_ticks_ff;

   logic [2:0]                         mode_ff, mode_in;
   logic                               arm_ff, arm_in;
   logic [15:0]                        speed_cmd_ff, speed_cmd_in;
   logic [mars_pkg::TargetWidth-1:0]   speed_div_ff, speed_div_in;
   logic [15:0]                        speed_last_ff, speed_last_in;
   logic [mars_pkg::ArmCntWidth-1:0]   arm_count_ff, arm_count_in, cnt_inc;
   logic [15:0]                        stop_count_ff, stop_count_in;
   logic                               must_stop;
   mars_pkg::rsp_item_type             res;

   mars_pkg::rsp_item_type oq_ff [2];
   logic                   owr_ff, owr_in;
   logic                   ord_ff, ord_in;
   logic [1:0]             oc_ff, oc_in;
   logic                   deq_out;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_min_ff    <= 16'd0;
         speed_max_ff    <= 16'hFFFF;
         arming_ticks_ff <= 16'd100;
         stop_ticks_ff   <= 16'd100;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            mars_pkg::CSR_SPEED_MIN:    speed_min_ff    <= csr_data;
            mars_pkg::CSR_SPEED_MAX:    speed_max_ff    <= csr_data;
            mars_pkg::CSR_ARMING_TICKS: arming_ticks_ff <= csr_data;
            mars_pkg::CSR_STOP_TICKS:   stop_ticks_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // take a request only when the result queue has room (or drains now)
   assign deq_out = rsp_pop && !rsp_empty;
   assign q_deq   = q_valid && ((oc_ff != 2'd2) || deq_out);

   always_comb begin
      mode_in       = mode_ff;
      arm_in        = arm_ff;
      speed_cmd_in  = speed_cmd_ff;
      speed_div_in  = speed_div_ff;
      speed_last_in = speed_last_ff;
      arm_count_in  = arm_count_ff;
      stop_count_in = stop_count_ff;
      res           = '0;
      must_stop     = (speed_cmd_ff == 16'd0) || !arm_ff;
      cnt_inc       = (arm_count_ff != mars_pkg::ARM_CNT_MAX) ?
                      arm_count_ff + 17'd1 : arm_count_ff;

      unique case (q_item.op)
         mars_pkg::OP_ARM: begin
            arm_in = q_item.arm_key;
         end
         mars_pkg::OP_SPEED: begin
            if (arm_ff) begin
               speed_cmd_in = q_item.speed;
               speed_div_in = q_item.speed_div;
            end
         end
         mars_pkg::OP_TELEM: begin
            res.telemetry_request = 1'b1;
         end
         mars_pkg::OP_TICK: begin
            unique case (mode_ff)
               mars_pkg::MODE_ARMING: begin
                  if (arm_ff && (speed_cmd_ff > speed_min_ff) &&
                      (speed_cmd_ff < speed_max_ff)) begin
                     if (cnt_inc > {1'b0, arming_ticks_ff}) begin
                        mode_in      = mars_pkg::MODE_ARMED;
                        arm_count_in = '0;
                     end else begin
                        arm_count_in = cnt_inc;
                     end
                  end else begin
                     arm_count_in = '0;
                  end
               end
               mars_pkg::MODE_ARMED: begin
                  res.ramp_valid    = 1'b1;
                  res.start_request = 1'b1;
                  stop_count_in     = 16'd0;
                  if (must_stop) begin
                     mode_in = mars_pkg::MODE_STOP;
                  end else if (q_item.accepted) begin
                     mode_in = mars_pkg::MODE_RUNINIT;
                  end else begin
                     mode_in = mars_pkg::MODE_ARMING;
                  end
               end
               mars_pkg::MODE_RUNINIT: begin
                  if (q_item.running) begin
                     res.ramp_valid = 1'b1;
                     speed_last_in  = speed_cmd_ff;
                     mode_in        = mars_pkg::MODE_RUN;
                  end
                  if (must_stop) begin
                     mode_in = mars_pkg::MODE_STOP;
                  end
               end
               mars_pkg::MODE_RUN: begin
                  if ((speed_cmd_ff != speed_last_ff) && q_item.running) begin
                     res.ramp_valid = 1'b1;
                     speed_last_in  = speed_cmd_ff;
                  end
                  if (must_stop) begin
                     mode_in = mars_pkg::MODE_STOP;
                  end
               end
               mars_pkg::MODE_STOP: begin
                  res.stop_request = 1'b1;
                  if (stop_count_ff >= stop_ticks_ff) begin
                     mode_in       = mars_pkg::MODE_ARMING;
                     stop_count_in = 16'd0;
                     arm_count_in  = '0;
                  end else begin
                     stop_count_in = stop_count_ff + 16'd1;
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase

      res.ramp_target = res.ramp_valid ? speed_div_ff : '0;
      res.mode        = mode_in;
      res.arm_enabled = arm_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= mars_pkg::MODE_ARMING;
         arm_ff        <= 1'b0;
         speed_cmd_ff  <= 16'd0;
         speed_div_ff  <= '0;
         speed_last_ff <= 16'd0;
         arm_count_ff  <= '0;
         stop_count_ff <= 16'd0;
      end else if (q_deq) begin
         mode_ff       <= mode_in;
         arm_ff        <= arm_in;
         speed_cmd_ff  <= speed_cmd_in;
         speed_div_ff  <= speed_div_in;
         speed_last_ff <= speed_last_in;
         arm_count_ff  <= arm_count_in;
         stop_count_ff <= stop_count_in;
      end
   end

   // result queue
   assign rsp_empty = (oc_ff == 2'd0);
   assign rsp_item  = oq_ff[ord_ff];

   always_comb begin
      owr_in = q_deq ? ~owr_ff : owr_ff;
      ord_in = deq_out ? ~ord_ff : ord_ff;
      oc_in  = oc_ff + {1'b0, q_deq} - {1'b0, deq_out};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owr_ff <= 1'b0;
         ord_ff <= 1'b0;
         oc_ff  <= 2'd0;
      end else begin
         owr_ff <= owr_in;
         ord_ff <= ord_in;
         oc_ff  <= oc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_deq) begin
         oq_ff[owr_ff] <= res;
      end
   end

endmodule

[design/motor_arming_run_sequencer_top.sv]
// Top level of the motor arming and run sequencer.
// A request waits in the front queue; the sequencer then registers its result in the
// result queue, where it can be popped. Throughput: one request per cycle while neither
// queue is full; the sequencer updates all of its state for each request it takes.
// Front and back each own a two-entry queue, so either side can stall alone.
// Reset (synchronous, active high): mode arming, disarmed, speed and counters zero,
// both queues empty, registers back to their defaults.
module motor_arming_run_sequencer_top (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_push,
   output logic                                req_full,
   input  logic                                req_action,
   input  logic [mars_pkg::IdWidth-1:0]        req_frame_id,
   input  logic [mars_pkg::PayloadWidth-1:0]   req_frame_payload,
   input  logic                                req_motor_running,
   input  logic                                req_start_accepted,
   // result channel
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic                                rsp_ramp_valid,
   output logic [mars_pkg::TargetWidth-1:0]    rsp_ramp_target,
   output logic                                rsp_start_request,
   output logic                                rsp_stop_request,
   output logic                                rsp_telemetry_request,
   output logic [2:0]                          rsp_mode,
   output logic                                rsp_arm_enabled,
   // configuration
   input  logic                                csr_wr_en,
   input  logic [mars_pkg::CsrIdxWidth-1:0]    csr_index,
   input  logic [mars_pkg::SpeedWidth-1:0]     csr_data
);

   mars_pkg::req_item_type q_item;
   logic                   q_valid;
   logic                   q_deq;
   mars_pkg::rsp_item_type rsp_item;

   // Front: decodes frame id / tick, precomputes speed/6, queues the request.
   mars_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_action         (req_action),
      .req_frame_id       (req_frame_id),
      .req_frame_payload  (req_frame_payload),
      .req_motor_running  (req_motor_running),
      .req_start_accepted (req_start_accepted),
      .req_full           (req_full),
      .q_item             (q_item),
      .q_valid            (q_valid),
      .q_deq              (q_deq)
   );

   // Back: runs the arming/run/stop sequencer and queues results.
   mars_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .q_item    (q_item),
      .q_valid   (q_valid),
      .q_deq     (q_deq),
      .rsp_item  (rsp_item),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

   assign rsp_ramp_valid        = rsp_item.ramp_valid;
   assign rsp_ramp_target       = rsp_item.ramp_target;
   assign rsp_start_request     = rsp_item.start_request;
   assign rsp_stop_request      = rsp_item.stop_request;
   assign rsp_telemetry_request = rsp_item.telemetry_request;
   assign rsp_mode              = rsp_item.mode;
   assign rsp_arm_enabled       = rsp_item.arm_enabled;

endmodule

[design/mars_checker.sv]
// Port-level checker for the motor arming and run sequencer, with its bind.
`include "motor_arming_run_sequencer_top_defines.svh"

module mars_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_full,
   input logic                                rsp_empty,
   input logic                                rsp_ramp_valid,
   input logic [mars_pkg::TargetWidth-1:0]    rsp_ramp_target,
   input logic                                rsp_start_request,
   input logic                                rsp_stop_request,
   input logic                                rsp_telemetry_request,
   input logic [2:0]                          rsp_mode
);

   `MARS_ASSERT_ALWAYS(a_reset_empty, reset |=> (rsp_empty && !req_full), "queues not empty after reset")
   `MARS_ASSERT(a_mode_legal, !rsp_empty |-> (rsp_mode <= mars_pkg::MODE_STOP), "illegal mode")
   `MARS_ASSERT(a_ramp_zero, (!rsp_empty && !rsp_ramp_valid) |-> (rsp_ramp_target == '0), "target without ramp")
   `MARS_ASSERT(a_telem_only, (!rsp_empty && rsp_telemetry_request) |-> (!rsp_ramp_valid && !rsp_start_request && !rsp_stop_request), "telemetry mixed with tick outputs")
   `MARS_ASSERT(a_start_stop, !rsp_empty |-> !(rsp_start_request && rsp_stop_request), "start and stop together")

endmodule

bind motor_arming_run_sequencer_top mars_checker u_mars_checker (.*);

[test/tb.sv]
// Self-checking testbench for the motor arming and run sequencer top level.
`timescale 1ns / 1ps

module tb;
   import mars_pkg::*;

   // Scoreboard: carries its own copy of the sequencer state and registers,
   // predicts one response per accepted request and checks responses in order.
   class sequencer_scoreboard;
      logic [SpeedWidth-1:0]  min_speed;
      logic [SpeedWidth-1:0]  max_speed;
      logic [SpeedWidth-1:0]  arm_ticks;
      logic [SpeedWidth-1:0]  hold_ticks;
      logic [2:0]             mode;
      logic                   arm_on;
      logic [SpeedWidth-1:0]  speed_cmd;
      logic [SpeedWidth-1:0]  speed_sent;
      logic [ArmCntWidth-1:0] arm_cnt;
      logic [SpeedWidth-1:0]  stop_cnt;
      rsp_item_type           expected_responses[$];
      int unsigned            errors;

      function new();
         min_speed  = '0;
         max_speed  = '1;
         arm_ticks  = 16'd100;
         hold_ticks = 16'd100;
         mode       = MODE_ARMING;
         arm_on     = 1'b0;
         speed_cmd  = '0;
         speed_sent = '0;
         arm_cnt    = '0;
         stop_cnt   = '0;
         errors     = 0;
      endfunction

      function void set_reg(logic [CsrIdxWidth-1:0] idx, logic [SpeedWidth-1:0] value);
         case (idx)
            CSR_SPEED_MIN:    min_speed  = value;
            CSR_SPEED_MAX:    max_speed  = value;
            CSR_ARMING_TICKS: arm_ticks  = value;
            CSR_STOP_TICKS:   hold_ticks = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_responses.size();
      endfunction

      // stop wins over any other next mode when speed is zero or disarmed
      function logic stop_needed();
         return (speed_cmd == '0) || !arm_on;
      endfunction

      function void note_request(logic action, logic [IdWidth-1:0] id,
                                 logic [PayloadWidth-1:0] payload,
                                 logic running, logic accepted);
         rsp_item_type rsp;
         rsp = '0;
         if (action) begin
            if (id == ID_ARM) begin
               arm_on = (payload[7:0] == ARM_KEY);
            end else if (id == ID_SPEED) begin
               if (arm_on) speed_cmd = payload[SpeedWidth-1:0];
            end else if (id == ID_TELEM) begin
               rsp.telemetry_request = 1'b1;
            end
         end else begin
            case (mode)
               MODE_ARMING: begin
                  if (arm_on && speed_cmd > min_speed && speed_cmd < max_speed) begin
                     if (arm_cnt != ARM_CNT_MAX) arm_cnt = arm_cnt + 1'b1;
                     if (arm_cnt > arm_ticks) begin
                        mode    = MODE_ARMED;
                        arm_cnt = '0;
                     end
                  end else begin
                     arm_cnt = '0;
                  end
               end
               MODE_ARMED: begin
                  rsp.ramp_valid    = 1'b1;
                  rsp.start_request = 1'b1;
                  mode     = accepted ? MODE_RUNINIT : MODE_ARMING;
                  stop_cnt = '0;
                  if (stop_needed()) mode = MODE_STOP;
               end
               MODE_RUNINIT: begin
                  if (running) begin
                     rsp.ramp_valid = 1'b1;
                     speed_sent     = speed_cmd;
                     mode           = MODE_RUN;
                  end
                  if (stop_needed()) mode = MODE_STOP;
               end
               MODE_RUN: begin
                  if (speed_cmd != speed_sent && running) begin
                     rsp.ramp_valid = 1'b1;
                     speed_sent     = speed_cmd;
                  end
                  if (stop_needed()) mode = MODE_STOP;
               end
               MODE_STOP: begin
                  rsp.stop_request = 1'b1;
                  if (stop_cnt >= hold_ticks) begin
                     mode     = MODE_ARMING;
                     stop_cnt = '0;
                     arm_cnt  = '0;
                  end else begin
                     stop_cnt = stop_cnt + 1'b1;
                  end
               end
               default: ;
            endcase
         end
         if (rsp.ramp_valid) rsp.ramp_target = TargetWidth'(speed_cmd / 16'd6);
         rsp.mode        = mode;
         rsp.arm_enabled = arm_on;
         expected_responses.push_back(rsp);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_response(rsp_item_type got);
         rsp_item_type want;
         if (expected_responses.size() == 0) begin
            $error("response popped with no request outstanding");
            errors++;
            return;
         end
         want = expected_responses.pop_front();
         compare_field("ramp_valid", 32'(want.ramp_valid), 32'(got.ramp_valid));
         compare_field("ramp_target", 32'(want.ramp_target), 32'(got.ramp_target));
         compare_field("start_request", 32'(want.start_request), 32'(got.start_request));
         compare_field("stop_request", 32'(want.stop_request), 32'(got.stop_request));
         compare_field("telemetry_request", 32'(want.telemetry_request),
                       32'(got.telemetry_request));
         compare_field("mode", 32'(want.mode), 32'(got.mode));
         compare_field("arm_enabled", 32'(want.arm_enabled), 32'(got.arm_enabled));
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_push;
   logic                    req_full;
   logic                    req_action;
   logic [IdWidth-1:0]      req_frame_id;
   logic [PayloadWidth-1:0] req_frame_payload;
   logic                    req_motor_running;
   logic                    req_start_accepted;
   logic                    rsp_empty;
   logic                    rsp_pop;
   logic                    rsp_ramp_valid;
   logic [TargetWidth-1:0]  rsp_ramp_target;
   logic                    rsp_start_request;
   logic                    rsp_stop_request;
   logic                    rsp_telemetry_request;
   logic [2:0]              rsp_mode;
   logic                    rsp_arm_enabled;
   logic                    csr_wr_en;
   logic [CsrIdxWidth-1:0]  csr_index;
   logic [SpeedWidth-1:0]   csr_data;

   // percentage of cycles the sender sits idle / the receiver refuses to pop
   int unsigned send_idle_pct = 0;
   int unsigned pop_stall_pct = 0;

   sequencer_scoreboard scoreboard;

   motor_arming_run_sequencer_top uut (
      .clock                 (clock),
      .reset                 (reset),
      .req_push              (req_push),
      .req_full              (req_full),
      .req_action            (req_action),
      .req_frame_id          (req_frame_id),
      .req_frame_payload     (req_frame_payload),
      .req_motor_running     (req_motor_running),
      .req_start_accepted    (req_start_accepted),
      .rsp_empty             (rsp_empty),
      .rsp_pop               (rsp_pop),
      .rsp_ramp_valid        (rsp_ramp_valid),
      .rsp_ramp_target       (rsp_ramp_target),
      .rsp_start_request     (rsp_start_request),
      .rsp_stop_request      (rsp_stop_request),
      .rsp_telemetry_request (rsp_telemetry_request),
      .rsp_mode              (rsp_mode),
      .rsp_arm_enabled       (rsp_arm_enabled),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Receiver: pop decision is redrawn every cycle, so stalls land on
   // every phase of the block's two-stage pipeline.
   always @(posedge clock) begin
      rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
   end

   // Response monitor: handshake values are the ones that stood before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         scoreboard.check_response({rsp_ramp_valid, rsp_ramp_target, rsp_start_request,
                                    rsp_stop_request, rsp_telemetry_request, rsp_mode,
                                    rsp_arm_enabled});
      end
   end

   // Push one request, after a random idle gap. On return push is left high;
   // the next call (or drain) is the only thing that changes it in that step.
   task automatic send_request(input logic action, input logic [IdWidth-1:0] id,
                               input logic [PayloadWidth-1:0] payload,
                               input logic running, input logic accepted);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push           <= 1'b1;
      req_action         <= action;
      req_frame_id       <= id;
      req_frame_payload  <= payload;
      req_motor_running  <= running;
      req_start_accepted <= accepted;
      do @(posedge clock); while (req_full);
      // noted here, not in a monitor, so drain never sees a stale count
      scoreboard.note_request(action, id, payload, running, accepted);
   endtask

   task automatic tick(input logic running, input logic accepted);
      // id and payload are don't-care on a tick: keep them random
      send_request(1'b0, IdWidth'($urandom), $urandom, running, accepted);
   endtask

   task automatic frame(input logic [IdWidth-1:0] id, input logic [PayloadWidth-1:0] payload);
      send_request(1'b1, id, payload, 1'($urandom_range(1)), 1'($urandom_range(1)));
   endtask

   // Sender holds off until every outstanding response has been popped.
   // One response per request, so an empty scoreboard means an idle block.
   task automatic drain();
      req_push <= 1'b0;
      while (scoreboard.pending() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrIdxWidth-1:0] idx, input logic [SpeedWidth-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      scoreboard.set_reg(idx, value);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_limits(input logic [SpeedWidth-1:0] lo, input logic [SpeedWidth-1:0] hi,
                             input logic [SpeedWidth-1:0] arm_t, input logic [SpeedWidth-1:0] stop_t);
      write_reg(CSR_SPEED_MIN, lo);
      write_reg(CSR_SPEED_MAX, hi);
      write_reg(CSR_ARMING_TICKS, arm_t);
      write_reg(CSR_STOP_TICKS, stop_t);
   endtask

   // Mostly ticks plus well-formed arm/speed frames so the sequencer keeps
   // cycling through all five modes; the rest is telemetry and junk ids.
   task automatic random_request();
      int unsigned             pick;
      int                      lo;
      int                      hi;
      logic [PayloadWidth-1:0] payload;
      logic [IdWidth-1:0]      id;
      pick    = $urandom_range(99);
      payload = $urandom;
      id      = IdWidth'($urandom);
      lo      = int'(scoreboard.min_speed);
      hi      = int'(scoreboard.max_speed);
      if (pick < 55) begin
         tick($urandom_range(9) != 0, $urandom_range(3) != 0);
      end else if (pick < 65) begin
         if ($urandom_range(99) < 85) payload[7:0] = ARM_KEY;
         frame(ID_ARM, payload);
      end else if (pick < 77) begin
         if ($urandom_range(99) < 6) begin
            payload[SpeedWidth-1:0] = '0;
         end else if ($urandom_range(99) < 80 && hi > lo + 1) begin
            payload[SpeedWidth-1:0] = SpeedWidth'($urandom_range(hi - 1, lo + 1));
         end
         frame(ID_SPEED, payload);
      end else if (pick < 85) begin
         frame(ID_TELEM, payload);
      end else begin
         // half fully random ids, half near-misses of the real ones
         if ($urandom_range(1) != 0)
            id = (ID_ARM + IdWidth'($urandom_range(2))) ^ (IdWidth'(1) << $urandom_range(28));
         frame(id, payload);
      end
   endtask

   initial begin
      scoreboard = new();
      reset              <= 1'b1;
      req_push           <= 1'b0;
      req_action         <= 1'b0;
      req_frame_id       <= '0;
      req_frame_payload  <= '0;
      req_motor_running  <= 1'b0;
      req_start_accepted <= 1'b0;
      csr_wr_en          <= 1'b0;
      csr_index          <= '0;
      csr_data           <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part: tight limits so every mode is reached quickly ----
      set_limits(16'd10, 16'd60000, 16'd1, 16'd2);
      frame(ID_SPEED, 32'hFFFF_1234);     // speed while disarmed: dropped
      tick(1'b1, 1'b1);                   // disarmed, stays arming
      frame('1, '1);                      // unknown id, all ones
      frame('0, '0);                      // unknown id, all zeros
      frame(ID_TELEM, 32'h0);
      frame(ID_ARM, 32'h0000_00AB);       // wrong key: disarm
      frame(ID_ARM, 32'hFFFF_FFAA);       // key in byte 0, junk above
      frame(ID_SPEED, 32'h0000_FFFF);     // above the upper limit
      tick(1'b0, 1'b0);                   // counter held at zero
      frame(ID_SPEED, 32'h5555_000A);     // equal to lower limit: not inside
      tick(1'b1, 1'b1);
      frame(ID_SPEED, 32'h0000_EA5F);     // just under the upper limit
      tick(1'b0, 1'b0);
      tick(1'b0, 1'b0);                   // count passes arming_ticks -> armed
      tick(1'b0, 1'b1);                   // start accepted -> run init, ramp
      tick(1'b1, 1'b0);                   // running -> run, ramp
      tick(1'b1, 1'b1);                   // same speed: no ramp
      frame(ID_SPEED, 32'hAAAA_3039);
      tick(1'b0, 1'b1);                   // speed changed but not running
      tick(1'b1, 1'b1);                   // ramp to new target
      frame(ID_ARM, 32'h0);               // disarm while running
      repeat (4) tick(1'b1, 1'b1);        // stop, hold, back to arming
      frame(ID_ARM, 32'h0000_00AA);
      repeat (3) tick(1'b1, 1'b0);        // armed tick without accept -> arming
      repeat (2) tick(1'b1, 1'b1);
      frame(ID_ARM, 32'h0000_0055);       // disarm while armed
      tick(1'b1, 1'b1);                   // stop overrides run init

      // ---- random phases, each with its own registers and a per-phase idling pattern ----
      for (int phase = 0; phase < 5; phase++) begin
         drain();
         case (phase)
            0: set_limits(16'd0, 16'hFFFF, 16'd0, 16'd0);
            1: set_limits(16'($urandom_range(2000)), 16'($urandom_range(65535, 30000)),
                          16'($urandom_range(4)), 16'($urandom_range(4)));
            2: set_limits(16'd100, 16'd200, 16'd2, 16'd3);
            3: set_limits(16'($urandom_range(20000)), 16'($urandom_range(65535, 40000)),
                          16'd1, 16'd6);
            default: set_limits(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF);
         endcase
         case (phase)
            0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
            1: begin send_idle_pct = 54; pop_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  pop_stall_pct = 54; end
            default: begin send_idle_pct = 27; pop_stall_pct = 27; end
         endcase
         repeat (phase == 4 ? 40 : 90) random_request();
      end

      drain();
      send_idle_pct = 0;
      pop_stall_pct = 0;
      // pipeline is two deep; leave room for any stray response
      repeat (10) @(posedge clock);
      if (scoreboard.errors == 0 && scoreboard.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run of roughly 450 requests.
   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

endmodule

[motor_arming_run_sequencer_top.f]
+incdir+design
design/mars_pkg.sv
design/mars_front.sv
design/mars_back.sv
design/motor_arming_run_sequencer_top.sv
design/mars_checker.sv
test/tb.sv
